### hw/rtl/ttfd_pkg.sv
// Shared types and constants for the tag text field decoder.
// Holds the result word layout, the field mode enum and the code constants.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ttfd_pkg;

	// Number of result words the queue between the two halves can hold.
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Encoding selector values.
	localparam logic [7:0] ENC_LATIN1 = 8'h00;
	localparam logic [7:0] ENC_UTF16  = 8'h01;

	// Byte-order mark bytes and the terminators.
	localparam logic [7:0]  BOM_BYTE_FF   = 8'hFF;
	localparam logic [7:0]  BOM_BYTE_FE   = 8'hFE;
	localparam logic [7:0]  TERM_BYTE     = 8'h00;
	localparam logic [15:0] TERM_UNIT     = 16'h0000;

	// End codes carried on end_code.
	localparam logic [1:0] END_NONE = 2'd0;
	localparam logic [1:0] END_TERM = 2'd1;
	localparam logic [1:0] END_SPAN = 2'd2;

	// Field decoding mode.
	typedef enum logic [1:0] {
		MODE_AWAIT  = 2'd0,
		MODE_DECODE = 2'd1,
		MODE_ERROR  = 2'd2
	} ttfd_mode_t;

	// One result word as it travels from the front half to the output.
	typedef struct packed {
		logic        char_valid;
		logic [15:0] char_code;
		logic [1:0]  end_code;
		logic        bad_encoding;
	} ttfd_result_t;

endpackage

### hw/rtl/ttfd_front.sv
// Front half of the tag text field decoder: accepts bytes and classifies them.
// Keeps the field state and forms at most one result word per accepted byte.
// Depends on ttfd_pkg.
`timescale 1ns / 1ps

module ttfd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [7:0]            data_byte,
	input  logic                  field_start,
	input  logic                  span_last,
	input  logic                  queue_full,
	output logic                  in_stall,
	output logic                  push,
	output ttfd_pkg::ttfd_result_t push_data
);
	import ttfd_pkg::*;

	ttfd_mode_t  mode_q, mode_d;
	logic        wide_q, wide_d;
	logic        held_q, held_d;
	logic [7:0]  held_byte_q, held_byte_d;
	logic        fresh_q, fresh_d;
	logic        le_q, le_d;

	logic        accept;
	logic        sel_ok;
	logic        le_bom;
	logic        be_bom;
	logic        bom_hit;
	logic        unit_le;
	logic [15:0] unit_code;
	logic        have;
	ttfd_result_t res;

	// A byte is taken whenever the queue has room for a possible result.
	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// Classification of the current byte against the held state.
	assign sel_ok    = (data_byte == ENC_LATIN1) || (data_byte == ENC_UTF16);
	assign le_bom    = (held_byte_q == BOM_BYTE_FF) && (data_byte == BOM_BYTE_FE);
	assign be_bom    = (held_byte_q == BOM_BYTE_FE) && (data_byte == BOM_BYTE_FF);
	assign bom_hit   = fresh_q && (le_bom || be_bom);
	// A fresh string without a mark is big-endian.
	assign unit_le   = fresh_q ? 1'b0 : le_q;
	assign unit_code = unit_le ? {data_byte, held_byte_q} : {held_byte_q, data_byte};

	// Next-state logic for the field state.
	always_comb begin
		mode_d      = mode_q;
		wide_d      = wide_q;
		held_d      = held_q;
		held_byte_d = held_byte_q;
		fresh_d     = fresh_q;
		le_d        = le_q;
		if (field_start) begin
			held_d      = 1'b0;
			held_byte_d = '0;
			fresh_d     = 1'b1;
			le_d        = 1'b0;
			if (sel_ok) begin
				wide_d = data_byte[0];
				mode_d = span_last ? MODE_AWAIT : MODE_DECODE;
			end else begin
				mode_d = MODE_ERROR;
			end
		end else if (mode_q == MODE_DECODE) begin
			if (!wide_q) begin
				if (data_byte == TERM_BYTE) begin
					fresh_d = 1'b1;
				end
			end else if (!held_q) begin
				held_d      = 1'b1;
				held_byte_d = data_byte;
			end else begin
				held_d      = 1'b0;
				held_byte_d = '0;
				if (fresh_q) begin
					fresh_d = 1'b0;
					le_d    = le_bom;
				end
				if (!bom_hit && unit_code == TERM_UNIT) begin
					fresh_d = 1'b1;
				end
			end
			// The span end drops any odd byte and waits for a new field.
			if (span_last) begin
				mode_d      = MODE_AWAIT;
				held_d      = 1'b0;
				held_byte_d = '0;
				fresh_d     = 1'b1;
			end
		end
	end

	// Result word for the current byte.
	always_comb begin
		have             = 1'b0;
		res.char_valid   = 1'b0;
		res.char_code    = '0;
		res.end_code     = span_last ? END_SPAN : END_NONE;
		res.bad_encoding = 1'b0;
		if (field_start) begin
			if (sel_ok) begin
				have = span_last;
			end else begin
				have             = 1'b1;
				res.bad_encoding = 1'b1;
			end
		end else begin
			unique case (mode_q)
				MODE_ERROR: begin
					have             = 1'b1;
					res.bad_encoding = 1'b1;
				end
				MODE_DECODE: begin
					if (!wide_q) begin
						have = 1'b1;
						if (data_byte == TERM_BYTE) begin
							res.end_code = span_last ? END_SPAN : END_TERM;
						end else begin
							res.char_valid = 1'b1;
							res.char_code  = {8'h00, data_byte};
						end
					end else if (!held_q || bom_hit) begin
						have = span_last;
					end else begin
						have = 1'b1;
						if (unit_code == TERM_UNIT) begin
							res.end_code = span_last ? END_SPAN : END_TERM;
						end else begin
							res.char_valid = 1'b1;
							res.char_code  = unit_code;
						end
					end
				end
				default: begin
					have = 1'b0;
				end
			endcase
		end
	end

	assign push      = accept && have;
	assign push_data = res;

	// Field state registers, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_AWAIT;
			wide_q      <= 1'b0;
			held_q      <= 1'b0;
			held_byte_q <= '0;
			fresh_q     <= 1'b1;
			le_q        <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			wide_q      <= wide_d;
			held_q      <= held_d;
			held_byte_q <= held_byte_d;
			fresh_q     <= fresh_d;
			le_q        <= le_d;
		end
	end

endmodule

### hw/rtl/ttfd_queue.sv
// Short result queue between the front and back halves of the decoder.
// A small register file with read and write pointers and a fill count.
// Depends on ttfd_pkg.
`timescale 1ns / 1ps

module ttfd_queue #(
	parameter int unsigned DEPTH = ttfd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ttfd_pkg::ttfd_result_t push_data,
	input  logic                  pop,
	output ttfd_pkg::ttfd_result_t pop_data,
	output logic                  full,
	output logic                  empty
);
	import ttfd_pkg::*;

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	ttfd_result_t          entry_q [DEPTH];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;

	assign full     = (count_q == CntFull);
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Storage: written at the write pointer only.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/ttfd_back.sv
// Back half of the decoder: the output register that presents result words.
// Pulls from the queue whenever the register is empty or being taken.
// Depends on ttfd_pkg.
`timescale 1ns / 1ps

module ttfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  queue_empty,
	input  ttfd_pkg::ttfd_result_t queue_data,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic                  char_valid,
	output logic [15:0]           char_code,
	output logic [1:0]            end_code,
	output logic                  bad_encoding
);
	import ttfd_pkg::*;

	logic         valid_q;
	ttfd_result_t word_q;

	// Refill the register when it holds nothing or its word leaves now.
	assign pop = !queue_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload register, loaded only on a pop.
	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= queue_data;
		end
	end

	assign out_valid    = valid_q;
	assign char_valid   = word_q.char_valid;
	assign char_code    = word_q.char_code;
	assign end_code     = word_q.end_code;
	assign bad_encoding = word_q.bad_encoding;

endmodule

### hw/rtl/tag_text_field_decoder_unit.sv
// Top level of the tag text field decoder.
// Joins the front half, the result queue and the output register.
// Depends on ttfd_pkg, ttfd_front, ttfd_queue and ttfd_back.
//
// Usage: bytes of a tag text field enter on the input channel (in_valid,
// in_stall) with field_start on the encoding selector and span_last on the
// final byte. Each accepted byte gives zero or one result word on the
// output channel (out_valid, out_stall): a character, an end marker, an
// error flag, or a mix of them.
// Throughput is one byte per cycle while in_stall is low; the field state
// updates in the cycle a byte is accepted. The edge that accepts a byte
// writes its result word into the queue; once at the head of the queue it
// moves into the output register, which drives out_valid, and the receiver
// takes it from there. When the receiver stalls, the output register holds
// its word and the queue fills; in_stall rises only once QUEUE_DEPTH words
// are waiting. Reset empties the queue and the output register and leaves
// the decoder waiting for a field_start byte.
`timescale 1ns / 1ps

module tag_text_field_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = ttfd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        field_start,
	input  logic        span_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        char_valid,
	output logic [15:0] char_code,
	output logic [1:0]  end_code,
	output logic        bad_encoding
);
	import ttfd_pkg::*;

	logic         push;
	logic         pop;
	logic         queue_full;
	logic         queue_empty;
	ttfd_result_t push_data;
	ttfd_result_t pop_data;

	// Byte intake and classification.
	ttfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.data_byte  (data_byte),
		.field_start(field_start),
		.span_last  (span_last),
		.queue_full (queue_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_data  (push_data)
	);

	// Result words waiting for the output side.
	ttfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	// Output register.
	ttfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_data  (pop_data),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.char_valid  (char_valid),
		.char_code   (char_code),
		.end_code    (end_code),
		.bad_encoding(bad_encoding)
	);

endmodule

### hw/rtl/ttfd_checker.sv
// Port-level checks for the tag text field decoder.
// Watches the channels over time; attached to the top level by bind.
// Depends on ttfd_pkg and tag_text_field_decoder_unit.
`timescale 1ns / 1ps

module ttfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        char_valid,
	input logic [15:0] char_code,
	input logic [1:0]  end_code,
	input logic        bad_encoding
);
	import ttfd_pkg::*;

	// While reset is held the block offers no word and takes input freely.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("block not idle during reset");

	// A stalled word stays on the port unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(end_code)
			&& $stable(char_valid) && $stable(bad_encoding))
		else $error("output word changed while stalled");

	// A character word never carries a zero code, and a non-character word carries zero.
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_valid && char_code != 16'h0000)
			|| (!char_valid && char_code == 16'h0000))
		else $error("char_code disagrees with char_valid");

	// An error word carries no character and no terminator end.
	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_encoding |-> !char_valid && end_code != END_TERM)
		else $error("error word carries decoded content");

	// A terminator end carries no character, and end codes stay in range.
	a_end_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_code == END_NONE && (char_valid || bad_encoding))
			|| (end_code == END_TERM && !char_valid)
			|| end_code == END_SPAN)
		else $error("end_code inconsistent with word contents");

endmodule

bind tag_text_field_decoder_unit ttfd_checker u_ttfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.char_valid  (char_valid),
	.char_code   (char_code),
	.end_code    (end_code),
	.bad_encoding(bad_encoding)
);

### dv/testbench.sv
// Self-checking testbench for tag_text_field_decoder_unit.
// Drives directed and random text fields through the byte channel and checks every result
// word against its directed row or an in-bench model. Depends on ttfd_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
	import ttfd_pkg::*;

	// How a row of the directed table is checked.
	typedef enum logic [1:0] {
		ROW_SILENT    = 2'd0,
		ROW_TYPED     = 2'd1,
		ROW_PREDICTED = 2'd2
	} row_check_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         start;
		logic         last;
		row_check_t   check;
		ttfd_result_t word;
	} dir_row_t;

	localparam ttfd_result_t NO_WORD = '0;
	localparam int DIR_ROWS = 28;
	localparam int RANDOM_BYTES = 700;

	// Directed rows: words are typed in where obvious or predicted; silent rows expect none.
	localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
		// A byte before any selector is ignored.
		'{8'h41, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		// Latin-1 field: characters, a terminator, and a terminator on the last byte.
		'{ENC_LATIN1, 1'b1, 1'b0, ROW_SILENT, NO_WORD},
		'{8'h41, 1'b0, 1'b0, ROW_TYPED, {1'b1, 16'h0041, END_NONE, 1'b0}},
		'{8'hFF, 1'b0, 1'b0, ROW_TYPED, {1'b1, 16'h00FF, END_NONE, 1'b0}},
		'{TERM_BYTE, 1'b0, 1'b0, ROW_TYPED, {1'b0, 16'h0000, END_TERM, 1'b0}},
		'{8'h01, 1'b0, 1'b0, ROW_PREDICTED, NO_WORD},
		'{TERM_BYTE, 1'b0, 1'b1, ROW_TYPED, {1'b0, 16'h0000, END_SPAN, 1'b0}},
		// Bad selector: the error holds through the span end and beyond.
		'{8'h07, 1'b1, 1'b0, ROW_TYPED, {1'b0, 16'h0000, END_NONE, 1'b1}},
		'{8'h55, 1'b0, 1'b0, ROW_TYPED, {1'b0, 16'h0000, END_NONE, 1'b1}},
		'{8'hAA, 1'b0, 1'b1, ROW_TYPED, {1'b0, 16'h0000, END_SPAN, 1'b1}},
		'{8'h33, 1'b0, 1'b0, ROW_TYPED, {1'b0, 16'h0000, END_NONE, 1'b1}},
		// Selectors that are also the last byte of their field.
		'{8'hFF, 1'b1, 1'b1, ROW_TYPED, {1'b0, 16'h0000, END_SPAN, 1'b1}},
		'{ENC_UTF16, 1'b1, 1'b1, ROW_TYPED, {1'b0, 16'h0000, END_SPAN, 1'b0}},
		// UTF-16 with no mark, then a little-endian mark, then a restart mid-unit.
		'{ENC_UTF16, 1'b1, 1'b0, ROW_SILENT, NO_WORD},
		'{8'hD8, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{8'h00, 1'b0, 1'b0, ROW_PREDICTED, NO_WORD},
		'{8'h00, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{8'h00, 1'b0, 1'b0, ROW_TYPED, {1'b0, 16'h0000, END_TERM, 1'b0}},
		'{BOM_BYTE_FF, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{BOM_BYTE_FE, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{8'h41, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{8'h00, 1'b0, 1'b0, ROW_PREDICTED, NO_WORD},
		'{BOM_BYTE_FE, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{ENC_LATIN1, 1'b1, 1'b0, ROW_SILENT, NO_WORD},
		'{8'h5A, 1'b0, 1'b1, ROW_TYPED, {1'b1, 16'h005A, END_SPAN, 1'b0}},
		// Big-endian mark that ends on the last byte of the span.
		'{ENC_UTF16, 1'b1, 1'b0, ROW_SILENT, NO_WORD},
		'{BOM_BYTE_FE, 1'b0, 1'b0, ROW_SILENT, NO_WORD},
		'{BOM_BYTE_FF, 1'b0, 1'b1, ROW_TYPED, {1'b0, 16'h0000, END_SPAN, 1'b0}}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        field_start;
	logic        span_last;
	logic        out_valid;
	logic        out_stall;
	logic        char_valid;
	logic [15:0] char_code;
	logic [1:0]  end_code;
	logic        bad_encoding;

	// Decoder state as the bench models it.
	ttfd_mode_t  dec_mode;
	logic        dec_wide;
	logic        dec_half_held;
	logic [7:0]  dec_held;
	logic        dec_fresh;
	logic        dec_little;

	ttfd_result_t decoded_due [$];
	int           fails;
	int           bytes_sent;
	bit           send_quiet;

	tag_text_field_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.field_start  (field_start),
		.span_last    (span_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_valid   (char_valid),
		.char_code    (char_code),
		.end_code     (end_code),
		.bad_encoding (bad_encoding)
	);

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advances the modelled decoder by one byte; returns 1 when a result word is due.
	function automatic bit decode_byte(input logic [7:0] b, input logic start,
			input logic last, output ttfd_result_t word);
		logic [1:0]  endc;
		logic [7:0]  lead;
		logic [15:0] code16;
		bit          have;
		bit          mark;
		endc = last ? END_SPAN : END_NONE;
		word = '0;
		have = 1'b0;
		mark = 1'b0;
		if (start) begin
			dec_half_held = 1'b0;
			dec_held = 8'h00;
			dec_fresh = 1'b1;
			dec_little = 1'b0;
			if (b == ENC_LATIN1 || b == ENC_UTF16) begin
				dec_wide = b[0];
				dec_mode = last ? MODE_AWAIT : MODE_DECODE;
				word.end_code = END_SPAN;
				return last;
			end
			dec_mode = MODE_ERROR;
			word.end_code = endc;
			word.bad_encoding = 1'b1;
			return 1'b1;
		end
		if (dec_mode == MODE_ERROR) begin
			word.end_code = endc;
			word.bad_encoding = 1'b1;
			return 1'b1;
		end
		if (dec_mode != MODE_DECODE)
			return 1'b0;

		if (!dec_wide) begin
			// Latin-1: a zero byte ends the string.
			if (b == TERM_BYTE) begin
				dec_fresh = 1'b1;
				if (!last)
					endc = END_TERM;
			end else begin
				word.char_valid = 1'b1;
				word.char_code = {8'h00, b};
			end
			have = 1'b1;
		end else if (!dec_half_held) begin
			dec_half_held = 1'b1;
			dec_held = b;
		end else begin
			// Second byte of a UTF-16 unit; the first unit of a string may be a mark.
			lead = dec_held;
			dec_half_held = 1'b0;
			dec_held = 8'h00;
			if (dec_fresh) begin
				dec_fresh = 1'b0;
				dec_little = 1'b0;
				if (lead == BOM_BYTE_FF && b == BOM_BYTE_FE) begin
					dec_little = 1'b1;
					mark = 1'b1;
				end else if (lead == BOM_BYTE_FE && b == BOM_BYTE_FF) begin
					mark = 1'b1;
				end
			end
			if (!mark) begin
				code16 = dec_little ? {b, lead} : {lead, b};
				if (code16 == TERM_UNIT) begin
					dec_fresh = 1'b1;
					if (!last)
						endc = END_TERM;
				end else begin
					word.char_valid = 1'b1;
					word.char_code = code16;
				end
				have = 1'b1;
			end
		end

		// The span end drops any held byte and always gives a word.
		if (last) begin
			dec_mode = MODE_AWAIT;
			dec_half_held = 1'b0;
			dec_held = 8'h00;
			dec_fresh = 1'b1;
			have = 1'b1;
		end
		word.end_code = endc;
		return have;
	endfunction

	// Idle gap before a byte: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (send_quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Offers one byte on the input channel and models it once it is taken.
	task automatic send_byte(input logic [7:0] b, input logic s, input logic l,
			output bit have, output ttfd_result_t word);
		int gap;
		gap = pick_gap();
		for (int i = 0; i < gap; i++) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		data_byte = b;
		field_start = s;
		span_last = l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		have = decode_byte(b, s, l, word);
		bytes_sent++;
	endtask

	task automatic send_checked(input logic [7:0] b, input logic s, input logic l);
		bit           have;
		ttfd_result_t word;
		send_byte(b, s, l, have, word);
		if (have)
			decoded_due = {decoded_due, word};
	endtask

	// One field with random content, mostly with a valid selector; sometimes cut short by the next selector.
	task automatic send_field();
		logic [7:0] body [$];
		logic [7:0] sel;
		int         r;
		int         strings;
		int         units;
		int         n;
		bit         wide;
		bit         cut;
		r = $urandom_range(0, 15);
		if (r < 7)
			sel = ENC_LATIN1;
		else if (r < 14)
			sel = ENC_UTF16;
		else
			sel = 8'($urandom_range(2, 255));
		wide = (sel == ENC_UTF16);
		strings = $urandom_range(1, 3);
		for (int k = 0; k < strings; k++) begin
			units = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
			if (wide) begin
				r = $urandom_range(0, 2);
				if (r == 0) begin
					body = {body, BOM_BYTE_FF};
					body = {body, BOM_BYTE_FE};
				end else if (r == 1) begin
					body = {body, BOM_BYTE_FE};
					body = {body, BOM_BYTE_FF};
				end
			end
			for (int u = 0; u < units; u++) begin
				if (wide) begin
					body = {body,
						($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255))};
					body = {body, 8'($urandom_range(0, 255))};
				end else begin
					body = {body, 8'($urandom_range(1, 255))};
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				body = {body, TERM_BYTE};
				if (wide)
					body = {body, TERM_BYTE};
			end
		end
		// An odd trailing byte now and then.
		if (wide && $urandom_range(0, 4) == 0)
			body = {body, 8'($urandom_range(0, 255))};
		cut = ($urandom_range(0, 9) == 0);
		n = body.size();
		send_checked(sel, 1'b1, n == 0 && !cut);
		for (int i = 0; i < n; i++)
			send_checked(body[i], 1'b0, i == n - 1 && !cut);
	endtask

	// Receiver: runs of stall and release of random length, with long clear stretches.
	initial begin
		int  run;
		int  r;
		bit  hold;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				hold = 1'b0;
				run = $urandom_range(1, 8);
			end else if (r < 85) begin
				hold = 1'b1;
				run = $urandom_range(1, 3);
			end else if (r < 95) begin
				hold = 1'b1;
				run = $urandom_range(4, 30);
			end else begin
				hold = 1'b0;
				run = $urandom_range(20, 80);
			end
			repeat (run) begin
				@(negedge clk);
				out_stall = hold;
			end
		end
	end

	// Each result word taken is compared with the oldest one due.
	always @(posedge clk) begin
		ttfd_result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_due.size() == 0) begin
				$error("unexpected result word: char_valid %0d char_code %h end_code %0d bad %0d",
					char_valid, char_code, end_code, bad_encoding);
				fails++;
			end else begin
				due = decoded_due.pop_front();
				if (char_valid !== due.char_valid) begin
					$error("char_valid: expected %0d, got %0d", due.char_valid, char_valid);
					fails++;
				end
				if (char_code !== due.char_code) begin
					$error("char_code: expected %h, got %h", due.char_code, char_code);
					fails++;
				end
				if (end_code !== due.end_code) begin
					$error("end_code: expected %0d, got %0d", due.end_code, end_code);
					fails++;
				end
				if (bad_encoding !== due.bad_encoding) begin
					$error("bad_encoding: expected %0d, got %0d", due.bad_encoding, bad_encoding);
					fails++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("FAIL tag_text_field_decoder_unit");
		$finish;
	end

	// Main sequence: reset, directed table, random fields and noise, then drain.
	initial begin
		bit           have;
		ttfd_result_t word;
		int           drain;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		field_start = 1'b0;
		span_last = 1'b0;
		fails = 0;
		bytes_sent = 0;
		send_quiet = 1'b0;
		dec_mode = MODE_AWAIT;
		dec_wide = 1'b0;
		dec_half_held = 1'b0;
		dec_held = 8'h00;
		dec_fresh = 1'b1;
		dec_little = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].last,
				have, word);
			case (DIRECTED_ROWS[i].check)
				ROW_TYPED: decoded_due = {decoded_due, DIRECTED_ROWS[i].word};
				ROW_PREDICTED: if (have) decoded_due = {decoded_due, word};
				default: ;
			endcase
		end

		while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
			if ($urandom_range(0, 11) == 0)
				send_quiet = !send_quiet;
			if ($urandom_range(0, 9) == 0) begin
				// Noise: random bytes with random field flags.
				repeat ($urandom_range(1, 8))
					send_checked(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
						$urandom_range(0, 5) == 0);
			end else begin
				send_field();
			end
		end
		@(negedge clk);
		in_valid = 1'b0;

		// Drain what is still due, then keep clocking so that a stray word would be seen.
		drain = 0;
		while (decoded_due.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		if (decoded_due.size() != 0) begin
			$error("%0d result words never arrived", decoded_due.size());
			fails++;
		end
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("PASS tag_text_field_decoder_unit");
		else
			$display("FAIL tag_text_field_decoder_unit");
		$finish;
	end

endmodule
